@@ rtl/core/scss_pkg.sv @@
// ----------------------------------------------------------------------------
// Sound channel sample step package.
// Shared widths, codes and the ADPCM tables of the sound channel sample step.
// ----------------------------------------------------------------------------
package scss_pkg;

    localparam int unsigned POSITION_BITS_DEF = 26;
    localparam int unsigned OUT_POS_W         = 26;
    localparam int unsigned SAMPLE_W          = 16;
    localparam int unsigned DATA_W            = 32;
    localparam int unsigned CFG_IDX_W         = 3;
    localparam int unsigned CFG_DATA_W        = 25;
    localparam int unsigned STEP_IDX_W        = 7;
    localparam int unsigned STEP_SIZE_W       = 15;
    localparam int unsigned LOOP_START_W      = 19;
    localparam int unsigned LOOP_LEN_W        = 25;

    // Commands.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Sample formats.
    localparam logic [1:0] FMT_PCM8  = 2'd0;
    localparam logic [1:0] FMT_PCM16 = 2'd1;
    localparam logic [1:0] FMT_ADPCM = 2'd2;
    localparam logic [1:0] FMT_GEN   = 2'd3;

    // Repeat mode that wraps to the loop start.
    localparam logic [1:0] REPEAT_LOOP = 2'd1;

    // Generator kinds.
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_NOISE  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_KIND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH   = 3'd5;

    localparam logic [STEP_IDX_W-1:0] INDEX_MAX = 7'd88;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX    = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN    = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG_SAT = 16'sh8001;

    localparam logic [15:0] NOISE_TAPS      = 16'h6000;
    localparam logic [15:0] GEN_START_POS   = 16'h7FFF;
    localparam logic [15:0] ADPCM_START_POS = 16'h0008;

    typedef logic [STEP_SIZE_W-1:0] t_step_size;

    function automatic t_step_size step_size(input logic [STEP_IDX_W-1:0] idx);
        t_step_size s;
        case (idx)
            7'd0:  s = 15'h0007;  7'd1:  s = 15'h0008;  7'd2:  s = 15'h0009;
            7'd3:  s = 15'h000A;  7'd4:  s = 15'h000B;  7'd5:  s = 15'h000C;
            7'd6:  s = 15'h000D;  7'd7:  s = 15'h000E;  7'd8:  s = 15'h0010;
            7'd9:  s = 15'h0011;  7'd10: s = 15'h0013;  7'd11: s = 15'h0015;
            7'd12: s = 15'h0017;  7'd13: s = 15'h0019;  7'd14: s = 15'h001C;
            7'd15: s = 15'h001F;  7'd16: s = 15'h0022;  7'd17: s = 15'h0025;
            7'd18: s = 15'h0029;  7'd19: s = 15'h002D;  7'd20: s = 15'h0032;
            7'd21: s = 15'h0037;  7'd22: s = 15'h003C;  7'd23: s = 15'h0042;
            7'd24: s = 15'h0049;  7'd25: s = 15'h0050;  7'd26: s = 15'h0058;
            7'd27: s = 15'h0061;  7'd28: s = 15'h006B;  7'd29: s = 15'h0076;
            7'd30: s = 15'h0082;  7'd31: s = 15'h008F;  7'd32: s = 15'h009D;
            7'd33: s = 15'h00AD;  7'd34: s = 15'h00BE;  7'd35: s = 15'h00D1;
            7'd36: s = 15'h00E6;  7'd37: s = 15'h00FD;  7'd38: s = 15'h0117;
            7'd39: s = 15'h0133;  7'd40: s = 15'h0151;  7'd41: s = 15'h0173;
            7'd42: s = 15'h0198;  7'd43: s = 15'h01C1;  7'd44: s = 15'h01EE;
            7'd45: s = 15'h0220;  7'd46: s = 15'h0256;  7'd47: s = 15'h0292;
            7'd48: s = 15'h02D4;  7'd49: s = 15'h031C;  7'd50: s = 15'h036C;
            7'd51: s = 15'h03C3;  7'd52: s = 15'h0424;  7'd53: s = 15'h048E;
            7'd54: s = 15'h0502;  7'd55: s = 15'h0583;  7'd56: s = 15'h0610;
            7'd57: s = 15'h06AB;  7'd58: s = 15'h0756;  7'd59: s = 15'h0812;
            7'd60: s = 15'h08E0;  7'd61: s = 15'h09C3;  7'd62: s = 15'h0ABD;
            7'd63: s = 15'h0BD0;  7'd64: s = 15'h0CFF;  7'd65: s = 15'h0E4C;
            7'd66: s = 15'h0FBA;  7'd67: s = 15'h114C;  7'd68: s = 15'h1307;
            7'd69: s = 15'h14EE;  7'd70: s = 15'h1706;  7'd71: s = 15'h1954;
            7'd72: s = 15'h1BDC;  7'd73: s = 15'h1EA5;  7'd74: s = 15'h21B6;
            7'd75: s = 15'h2515;  7'd76: s = 15'h28CA;  7'd77: s = 15'h2CDF;
            7'd78: s = 15'h315B;  7'd79: s = 15'h364B;  7'd80: s = 15'h3BB9;
            7'd81: s = 15'h41B2;  7'd82: s = 15'h4844;  7'd83: s = 15'h4F7E;
            7'd84: s = 15'h5771;  7'd85: s = 15'h602F;  7'd86: s = 15'h69CE;
            7'd87: s = 15'h7462;
            default: s = 15'h7FFF;
        endcase
        return s;
    endfunction

    function automatic logic signed [4:0] index_adjust(input logic [2:0] code);
        logic signed [4:0] a;
        case (code)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/core/sound_channel_sample_step.sv @@
// ----------------------------------------------------------------------------
// Sound channel sample step.
// One sound channel: start and step words drive PCM8, PCM16, IMA ADPCM,
// square and noise sample generation with loop or stop at the end of data.
// ----------------------------------------------------------------------------
//   Channel   Handshake                  Payload
//   input     i_in_valid / o_in_ready    i_cmd, i_data
//   output    o_out_valid / i_out_ready  o_sample, o_next_position,
//                                        o_active, o_looped
//   config    i_cfg_we                   i_cfg_index, i_cfg_data
//
// A word and its result are each registered; one word is taken every cycle
// unless stalled. The single pass from the input register through the ADPCM
// step table and the saturating adds to the result register sets the clock.
// Reset clears all configuration, channel state and both valid bits. A
// stalled result holds while one more word waits in the input register.
// ----------------------------------------------------------------------------
module sound_channel_sample_step #(
    parameter int unsigned POSITION_BITS = scss_pkg::POSITION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [scss_pkg::DATA_W-1:0]       i_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [scss_pkg::SAMPLE_W-1:0] o_sample,
    output logic [scss_pkg::OUT_POS_W-1:0]    o_next_position,
    output logic                              o_active,
    output logic                              o_looped,
    input  logic                              i_cfg_we,
    input  logic [scss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned PW = POSITION_BITS;
    localparam int unsigned CW = (PW > scss_pkg::OUT_POS_W) ? PW : scss_pkg::OUT_POS_W;
    localparam int unsigned SW = scss_pkg::SAMPLE_W;
    localparam int unsigned XW = scss_pkg::STEP_IDX_W;

    logic [1:0]                           r_sample_format;
    logic [1:0]                           r_repeat_mode;
    logic [2:0]                           r_duty_level;
    logic [1:0]                           r_channel_kind;
    logic [scss_pkg::LOOP_START_W-1:0]    r_loop_start;
    logic [scss_pkg::LOOP_LEN_W-1:0]      r_loop_length;

    logic signed [SW-1:0] r_cur_sample, n_cur_sample;
    logic [XW-1:0]        r_step_index, n_step_index;
    logic [XW-1:0]        r_loop_step_index, n_loop_step_index;
    logic signed [SW-1:0] r_loop_sample, n_loop_sample;
    logic [PW-1:0]        r_position, n_position;
    logic                 r_running, n_running;
    logic                 n_looped;

    logic                            r_in_valid;
    logic                            r_cmd;
    logic [scss_pkg::DATA_W-1:0]     r_data;
    logic                            r_out_valid;
    logic signed [SW-1:0]            r_out_sample;
    logic [scss_pkg::OUT_POS_W-1:0]  r_out_position;
    logic                            r_out_active;
    logic                            r_out_looped;

    logic out_free;
    logic advance;

    logic [XW-1:0]           adp_idx;
    scss_pkg::t_step_size    adp_step;
    logic [3:0]              adp_code;
    logic [16:0]             adp_diff;
    logic signed [17:0]      adp_cur_ext;
    logic signed [17:0]      adp_sum;
    logic signed [SW-1:0]    adp_sample;
    logic signed [4:0]       adp_adjust;
    logic signed [7:0]       adp_idx_sum;
    logic [XW-1:0]           adp_new_idx;
    logic [XW-1:0]           hdr_idx;
    logic [2:0]              sq_pos;
    logic [PW-1:0]           noise_shift;
    logic [CW-1:0]           loop_start_ext;
    logic [CW-1:0]           end_pos;
    logic [CW-1:0]           n_position_ext;
    logic [CW-1:0]           out_position_ext;
    logic                    at_loop_start;
    logic                    data_step;

    // Handshake between the input register and the result register.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // ADPCM decode of one nibble.
    assign adp_idx     = (r_step_index > scss_pkg::INDEX_MAX) ? scss_pkg::INDEX_MAX
                                                              : r_step_index;
    assign adp_step    = scss_pkg::step_size(adp_idx);
    assign adp_code    = r_position[0] ? r_data[7:4] : r_data[3:0];
    assign adp_diff    = 17'(adp_step >> 3)
                       + (adp_code[0] ? 17'(adp_step >> 2) : 17'd0)
                       + (adp_code[1] ? 17'(adp_step >> 1) : 17'd0)
                       + (adp_code[2] ? 17'(adp_step)      : 17'd0);
    assign adp_cur_ext = {{2{r_cur_sample[SW-1]}}, r_cur_sample};
    assign adp_sum     = adp_code[3] ? adp_cur_ext - $signed({1'b0, adp_diff})
                                     : adp_cur_ext + $signed({1'b0, adp_diff});

    always_comb begin
        if (adp_code[3]) begin
            adp_sample = (adp_sum < -18'sd32767) ? scss_pkg::SAMPLE_NEG_SAT
                                                 : adp_sum[SW-1:0];
        end else begin
            adp_sample = (adp_sum > 18'sd32767) ? scss_pkg::SAMPLE_MAX
                                                : adp_sum[SW-1:0];
        end
    end

    assign adp_adjust  = scss_pkg::index_adjust(adp_code[2:0]);
    assign adp_idx_sum = $signed({1'b0, adp_idx})
                       + {{3{adp_adjust[4]}}, adp_adjust};

    always_comb begin
        if (adp_idx_sum < 8'sd0) begin
            adp_new_idx = '0;
        end else if (adp_idx_sum > $signed({1'b0, scss_pkg::INDEX_MAX})) begin
            adp_new_idx = scss_pkg::INDEX_MAX;
        end else begin
            adp_new_idx = adp_idx_sum[XW-1:0];
        end
    end

    assign hdr_idx = (r_data[22:16] > scss_pkg::INDEX_MAX) ? scss_pkg::INDEX_MAX
                                                           : r_data[22:16];

    assign sq_pos           = r_position[2:0] + 3'd1;
    assign noise_shift      = r_position >> 1;
    assign loop_start_ext   = CW'(r_loop_start);
    assign end_pos          = loop_start_ext + CW'(r_loop_length);
    assign at_loop_start    = (CW'(r_position) == loop_start_ext);
    assign out_position_ext = CW'(n_position);

    always_comb begin
        n_cur_sample      = r_cur_sample;
        n_step_index      = r_step_index;
        n_loop_step_index = r_loop_step_index;
        n_loop_sample     = r_loop_sample;
        n_position        = r_position;
        n_running         = r_running;
        n_looped          = 1'b0;
        data_step         = 1'b0;
        n_position_ext    = '0;

        if (r_cmd == scss_pkg::CMD_START) begin
            case (r_sample_format)
                scss_pkg::FMT_ADPCM: begin
                    n_cur_sample = r_data[SW-1:0];
                    n_step_index = hdr_idx;
                    n_position   = PW'(scss_pkg::ADPCM_START_POS);
                end
                scss_pkg::FMT_GEN: begin
                    n_cur_sample = '0;
                    n_position   = PW'(scss_pkg::GEN_START_POS);
                end
                default: begin
                    n_cur_sample = '0;
                    n_position   = '0;
                end
            endcase
            n_running = 1'b1;
        end else if (r_running) begin
            case (r_sample_format)
                scss_pkg::FMT_PCM8: begin
                    data_step    = 1'b1;
                    n_cur_sample = {r_data[7:0], 8'h00};
                    n_position   = r_position + PW'(2);
                end
                scss_pkg::FMT_PCM16: begin
                    data_step    = 1'b1;
                    n_cur_sample = r_data[SW-1:0];
                    n_position   = r_position + PW'(4);
                end
                scss_pkg::FMT_ADPCM: begin
                    data_step = 1'b1;
                    if (at_loop_start) begin
                        n_loop_step_index = adp_idx;
                        n_loop_sample     = r_cur_sample;
                    end
                    n_cur_sample = adp_sample;
                    n_step_index = adp_new_idx;
                    n_position   = r_position + PW'(1);
                end
                default: begin
                    if (r_channel_kind == scss_pkg::KIND_SQUARE) begin
                        n_position   = PW'(sq_pos);
                        n_cur_sample = (sq_pos < r_duty_level) ? scss_pkg::SAMPLE_MIN
                                                               : scss_pkg::SAMPLE_MAX;
                    end else if (r_channel_kind == scss_pkg::KIND_NOISE) begin
                        if (r_position[0]) begin
                            n_position   = noise_shift ^ PW'(scss_pkg::NOISE_TAPS);
                            n_cur_sample = scss_pkg::SAMPLE_MIN;
                        end else begin
                            n_position   = noise_shift;
                            n_cur_sample = scss_pkg::SAMPLE_MAX;
                        end
                    end
                end
            endcase

            n_position_ext = CW'(n_position);
            if (data_step && (n_position_ext >= end_pos)) begin
                if (r_repeat_mode == scss_pkg::REPEAT_LOOP) begin
                    n_position = loop_start_ext[PW-1:0];
                    if (r_sample_format == scss_pkg::FMT_ADPCM) begin
                        n_step_index = (n_loop_step_index > scss_pkg::INDEX_MAX)
                                     ? scss_pkg::INDEX_MAX : n_loop_step_index;
                        n_cur_sample = n_loop_sample;
                    end
                    n_looped = 1'b1;
                end else begin
                    n_running = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_format <= '0;
            r_repeat_mode   <= '0;
            r_duty_level    <= '0;
            r_channel_kind  <= '0;
            r_loop_start    <= '0;
            r_loop_length   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scss_pkg::CFG_SAMPLE_FORMAT: r_sample_format <= i_cfg_data[1:0];
                scss_pkg::CFG_REPEAT_MODE:   r_repeat_mode   <= i_cfg_data[1:0];
                scss_pkg::CFG_DUTY_LEVEL:    r_duty_level    <= i_cfg_data[2:0];
                scss_pkg::CFG_CHANNEL_KIND:  r_channel_kind  <= i_cfg_data[1:0];
                scss_pkg::CFG_LOOP_START:
                    r_loop_start <= i_cfg_data[scss_pkg::LOOP_START_W-1:0];
                scss_pkg::CFG_LOOP_LENGTH:
                    r_loop_length <= i_cfg_data[scss_pkg::LOOP_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd  <= i_cmd;
            r_data <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_sample      <= '0;
            r_step_index      <= '0;
            r_loop_step_index <= '0;
            r_loop_sample     <= '0;
            r_position        <= '0;
            r_running         <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_cur_sample      <= n_cur_sample;
                r_step_index      <= n_step_index;
                r_loop_step_index <= n_loop_step_index;
                r_loop_sample     <= n_loop_sample;
                r_position        <= n_position;
                r_running         <= n_running;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_sample   <= n_cur_sample;
            r_out_position <= out_position_ext[scss_pkg::OUT_POS_W-1:0];
            r_out_active   <= n_running;
            r_out_looped   <= n_looped;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample        = r_out_sample;
    assign o_next_position = r_out_position;
    assign o_active        = r_out_active;
    assign o_looped        = r_out_looped;

endmodule

@@ rtl/core/scss_checker.sv @@
// ----------------------------------------------------------------------------
// Sound channel sample step checker.
// Port-level assertions on the handshakes and results of the channel.
// ----------------------------------------------------------------------------
module scss_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic signed [scss_pkg::SAMPLE_W-1:0]   o_sample,
    input logic [scss_pkg::OUT_POS_W-1:0]         o_next_position,
    input logic                                   o_active,
    input logic                                   o_looped
);

    // A wrap to the loop start keeps the channel playing.
    a_looped_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_looped) |-> o_active)
        else $error("looped result reports an inactive channel");

    // A stalled result word holds.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_sample)
            && $stable(o_next_position) && $stable(o_active) && $stable(o_looped)))
        else $error("stalled result word changed");

    // With no result waiting, the input side is always open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while the result register is empty");

    // An accepted word reaches the output when the result is not stalled.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 i_out_ready |=> o_out_valid)
        else $error("accepted word produced no result");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind sound_channel_sample_step scss_checker u_scss_checker (.*);
